### hw/rtl/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and constants for the cycle counter frequency scale estimator.
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int unsigned CNT_W   = 64;
    localparam int unsigned KHZ_W   = 32;
    localparam int unsigned SCALE_W = 11;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned MULT_W  = 30;
    localparam int unsigned SCALE_SHIFT = 10;

    localparam logic [31:0] USEC_PER_SEC_K = 32'd1000000;
    localparam logic [SCALE_W-1:0] SCALE_ONE = 11'd1024;

    localparam logic [CFG_W-1:0]  RST_MIN_SAMPLE_TICKS = 32'd58;
    localparam logic [MULT_W-1:0] RST_TICK_NS_MULT     = 30'd1250;
    localparam logic [CFG_W-1:0]  RST_TICK_NS_DIV      = 32'd24;
    localparam logic [CFG_W-1:0]  RST_MAX_FREQ_KHZ     = 32'd2016000;

    typedef enum logic [1:0] {
        ACT_ACCUM    = 2'd0,
        ACT_RESYNC   = 2'd1,
        ACT_EVAL     = 2'd2,
        ACT_ACC_EVAL = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_MIN_SAMPLE_TICKS = 2'd0,
        CFG_TICK_NS_MULT     = 2'd1,
        CFG_TICK_NS_DIV      = 2'd2,
        CFG_MAX_FREQ_KHZ     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CHECK,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        DK_NS,
        DK_FREQ,
        DK_SCALE
    } t_div_kind;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_RUN,
        DV_DONE
    } t_div_state;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] num_hi;
        logic [CNT_W-1:0] num_lo;
        logic [CNT_W-1:0] den;
    } t_div_req;

endpackage

### hw/rtl/fcs_div.sv
// ----------------------------------------------------------------------------
// fcs_div
// Radix-2 restoring divider, 128 by 64 bits, quotient saturated to 64 bits.
// ----------------------------------------------------------------------------
module fcs_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fcs_pkg::t_div_req     i_req,
    output logic                  o_done,
    output logic [fcs_pkg::CNT_W-1:0] o_quo
);
    import fcs_pkg::*;

    t_div_state r_state, n_state;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] r_den;
    logic [5:0]       r_cnt;

    logic [CNT_W-1:0] w_sh;
    logic             w_ge;

    assign w_sh = {r_rem[CNT_W-2:0], r_lo[CNT_W-1]};
    assign w_ge = r_rem[CNT_W-1] || (w_sh >= r_den);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE:  if (i_req.start) n_state = DV_CHECK;
            DV_CHECK: n_state = (r_rem >= r_den) ? DV_DONE : DV_RUN;
            DV_RUN:   if (r_cnt == 6'd0) n_state = DV_DONE;
            DV_DONE:  n_state = DV_IDLE;
            default:  n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == DV_DONE);
        o_quo  = r_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            DV_IDLE: begin
                r_rem <= i_req.num_hi;
                r_lo  <= i_req.num_lo;
                r_den <= i_req.den;
                r_cnt <= 6'd63;
            end
            DV_CHECK: begin
                if (r_rem >= r_den) begin
                    r_lo <= '1;
                end
            end
            DV_RUN: begin
                r_rem <= w_ge ? (w_sh - r_den) : w_sh;
                r_lo  <= {r_lo[CNT_W-2:0], w_ge};
                r_cnt <= r_cnt - 6'd1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

### hw/rtl/cycle_counter_freq_scale_estimator.sv
// ----------------------------------------------------------------------------
// cycle_counter_freq_scale_estimator
// Window accumulator and frequency/scale evaluator over wrapping counters.
// ----------------------------------------------------------------------------
// Each input beat carries an action and a snapshot of the constant-rate and
// core cycle counters and yields exactly one output beat. Accumulate and
// resync beats pass from the update state straight to the output, and an
// evaluate beat whose window is too short leaves after the window check. An
// evaluate beat with a long enough window makes three passes through one
// shared radix-2 divider (tick to ns, cycles to kHz, kHz to scale), with two
// 64x32 products built from two passes of one 32x32 multiplier; a zero ns
// count skips the kHz pass and its product. The input is not ready while an
// item is in work; a finished beat waits in the output register while the
// next input beat is taken.
module cycle_counter_freq_scale_estimator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // const_count[63:0], core_count[127:64]
    input  logic [1:0]    s_axis_tuser,  // action[1:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [47:0]   m_axis_tdata,  // freq_scale[10:0], measured_khz[42:11], zero
    output logic          m_axis_tuser   // scale_valid[0]
);
    import fcs_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_min_ticks;
    logic [MULT_W-1:0] r_ns_mult;
    logic [CFG_W-1:0]  r_ns_div;
    logic [CFG_W-1:0]  r_max_khz;

    logic [CNT_W-1:0] r_prev_const, r_prev_core;
    logic [CNT_W-1:0] r_acc_const, r_acc_core;
    logic             r_stale;

    t_action          r_action;
    logic [CNT_W-1:0] r_cur_const, r_cur_core;

    t_div_kind        r_kind;
    logic [63:0]      r_plo, r_phi;
    logic [CNT_W-1:0] r_ns;
    logic [KHZ_W-1:0] r_freq;
    logic [SCALE_W-1:0] r_scale;
    logic             r_res_valid;

    logic             r_m_valid;
    logic [47:0]      r_m_data;
    logic             r_m_user;

    logic             w_accept;
    logic             w_do_acc, w_do_eval;
    logic [CNT_W-1:0] w_dc, w_dk;
    logic [CNT_W-1:0] w_mul_a;
    logic [31:0]      w_mul_b;
    logic [31:0]      w_mul_x;
    logic [63:0]      w_mul_p;
    logic [95:0]      w_prod;
    logic             w_out_free;
    t_div_req         w_div_req;
    logic             w_div_done;
    logic [CNT_W-1:0] w_div_quo;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_dc = r_cur_const - r_prev_const;
    assign w_dk = r_cur_core - r_prev_core;
    assign w_mul_a = (r_kind == DK_NS) ? r_acc_const : r_acc_core;
    assign w_mul_b = (r_kind == DK_NS) ? {2'b00, r_ns_mult} : USEC_PER_SEC_K;
    assign w_mul_x = (r_state == ST_MUL_HI) ? w_mul_a[63:32] : w_mul_a[31:0];
    assign w_mul_p = {32'd0, w_mul_x} * {32'd0, w_mul_b};
    assign w_prod  = {r_phi, 32'd0} + {32'd0, r_plo};

    always_comb begin
        w_do_acc  = 1'b0;
        w_do_eval = 1'b0;
        case (r_action)
            ACT_ACCUM:    w_do_acc = 1'b1;
            ACT_EVAL:     w_do_eval = 1'b1;
            ACT_ACC_EVAL: begin
                w_do_acc  = 1'b1;
                w_do_eval = 1'b1;
            end
            default:      w_do_acc = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (w_accept) n_state = ST_UPDATE;
            ST_UPDATE:    n_state = w_do_eval ? ST_CHECK : ST_OUT;
            ST_CHECK:     n_state = ({32'd0, r_min_ticks} <= r_acc_const) ? ST_MUL_LO : ST_OUT;
            ST_MUL_LO:    n_state = ST_MUL_HI;
            ST_MUL_HI:    n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    unique case (r_kind)
                        DK_NS:   n_state = (w_div_quo == '0) ? ST_DIV_START : ST_MUL_LO;
                        DK_FREQ: n_state = ST_DIV_START;
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_OUT:       if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready    = (r_state == ST_IDLE);
        w_div_req.start  = (r_state == ST_DIV_START);
        if (r_kind == DK_SCALE) begin
            w_div_req.num_hi = '0;
            w_div_req.num_lo = {22'd0, r_freq, {SCALE_SHIFT{1'b0}}};
            w_div_req.den    = {32'd0, r_max_khz};
        end else begin
            w_div_req.num_hi = {32'd0, w_prod[95:64]};
            w_div_req.num_lo = w_prod[63:0];
            w_div_req.den    = (r_kind == DK_NS) ? {32'd0, r_ns_div} : r_ns;
        end
    end

    fcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ticks <= RST_MIN_SAMPLE_TICKS;
            r_ns_mult   <= RST_TICK_NS_MULT;
            r_ns_div    <= RST_TICK_NS_DIV;
            r_max_khz   <= RST_MAX_FREQ_KHZ;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_SAMPLE_TICKS: r_min_ticks <= i_cfg_wdata;
                CFG_TICK_NS_MULT:     r_ns_mult   <= i_cfg_wdata[MULT_W-1:0];
                CFG_TICK_NS_DIV:      r_ns_div    <= i_cfg_wdata;
                CFG_MAX_FREQ_KHZ:     r_max_khz   <= i_cfg_wdata;
                default:              r_max_khz   <= r_max_khz;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_const <= '0;
            r_prev_core  <= '0;
            r_acc_const  <= '0;
            r_acc_core   <= '0;
            r_stale      <= 1'b0;
            r_res_valid  <= 1'b0;
            r_kind       <= DK_NS;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_action    <= t_action'(s_axis_tuser);
                        r_cur_const <= s_axis_tdata[63:0];
                        r_cur_core  <= s_axis_tdata[127:64];
                    end
                end
                ST_UPDATE: begin
                    r_res_valid <= 1'b0;
                    r_kind      <= DK_NS;
                    if (w_do_acc) begin
                        if (r_stale && (w_dc >= {32'd0, r_min_ticks})) begin
                            r_acc_const <= w_dc;
                            r_acc_core  <= w_dk;
                            r_stale     <= 1'b0;
                        end else begin
                            r_acc_const <= r_acc_const + w_dc;
                            r_acc_core  <= r_acc_core + w_dk;
                        end
                    end
                    if (r_action != ACT_EVAL) begin
                        r_prev_const <= r_cur_const;
                        r_prev_core  <= r_cur_core;
                    end
                end
                ST_CHECK: begin
                    if (({32'd0, r_min_ticks} > r_acc_const) && (r_acc_const != '0)) begin
                        r_stale <= 1'b1;
                    end
                end
                ST_MUL_LO: r_plo <= w_mul_p;
                ST_MUL_HI: r_phi <= w_mul_p;
                ST_DIV_WAIT: begin
                    if (w_div_done) begin
                        unique case (r_kind)
                            DK_NS: begin
                                r_ns <= w_div_quo;
                                if (w_div_quo == '0) begin
                                    r_freq <= r_max_khz;
                                    r_kind <= DK_SCALE;
                                end else begin
                                    r_kind <= DK_FREQ;
                                end
                            end
                            DK_FREQ: begin
                                r_freq <= (w_div_quo > {32'd0, r_max_khz}) ? r_max_khz
                                                                           : w_div_quo[31:0];
                                r_kind <= DK_SCALE;
                            end
                            default: begin
                                r_scale     <= (r_max_khz == '0) ? '0 : w_div_quo[SCALE_W-1:0];
                                r_res_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_OUT: begin
                    if (w_out_free && r_res_valid) begin
                        r_acc_const <= '0;
                        r_acc_core  <= '0;
                        r_stale     <= 1'b0;
                    end
                end
                default: begin
                    r_kind <= r_kind;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_m_user <= r_res_valid;
            if (r_res_valid) begin
                r_m_data <= {5'd0, r_freq, r_scale};
            end else begin
                r_m_data <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    a_khz_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[42:11] <= r_max_khz))
        else $error("measured kHz above cap");

    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:0] <= SCALE_ONE))
        else $error("scale above full speed");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid beat carries data");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV_WAIT))
        else $error("divider finished outside wait state");

    a_stale_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && r_acc_const == '0) |=> !$rose(r_stale))
        else $error("empty window marked stale");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the cycle counter frequency scale estimator.
// Drives counter snapshots with accumulate, resync and evaluate actions over
// the input stream, predicts every output beat with a bit-accurate model of
// the window accumulators and the ns/kHz/scale arithmetic, and checks each
// output beat in order. Runs directed corner cases, then random well-formed
// windows mixed with noise under several register settings, with random
// idling on both streams, one long output stall and one input pause.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcs_pkg::*;

    typedef struct packed {
        logic               valid;
        logic [SCALE_W-1:0] scale;
        logic [KHZ_W-1:0]   khz;
    } t_scale_beat;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [31:0]   i_cfg_wdata;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata;  // const_count[63:0], core_count[127:64]
    logic [1:0]    s_axis_tuser;  // action[1:0]
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [47:0]   m_axis_tdata;  // freq_scale[10:0], measured_khz[42:11], zero
    logic          m_axis_tuser;  // scale_valid[0]

    cycle_counter_freq_scale_estimator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic [CNT_W-1:0]  mdl_prev_const;
    logic [CNT_W-1:0]  mdl_prev_core;
    logic [CNT_W-1:0]  mdl_acc_const;
    logic [CNT_W-1:0]  mdl_acc_core;
    logic              mdl_stale;
    logic [CFG_W-1:0]  mdl_min;
    logic [MULT_W-1:0] mdl_mult;
    logic [CFG_W-1:0]  mdl_div;
    logic [CFG_W-1:0]  mdl_max;

    t_scale_beat       pending_scales[$];
    int                err_cnt = 0;
    int                items_sent = 0;
    bit                no_idle = 1'b0;
    int                hold_req = 0;
    logic [CNT_W-1:0]  gen_const = '0;
    logic [CNT_W-1:0]  gen_core = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[cycle_counter_freq_scale_estimator] ERROR");
        $finish;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 17));
    endfunction

    function automatic void drop_window();
        mdl_acc_const = '0;
        mdl_acc_core  = '0;
        mdl_stale     = 1'b0;
    endfunction

    function automatic t_scale_beat compute_freq_scale(input t_action act,
                                                       input logic [CNT_W-1:0] cur_const,
                                                       input logic [CNT_W-1:0] cur_core);
        logic [CNT_W-1:0] d_const;
        logic [CNT_W-1:0] d_core;
        logic [CNT_W-1:0] ns;
        logic [CNT_W-1:0] khz_full;
        logic [CNT_W-1:0] scale_full;
        logic [127:0]     prod;
        logic [127:0]     quot;
        t_scale_beat      beat;
        beat = '0;
        if (act == ACT_ACCUM || act == ACT_ACC_EVAL) begin
            d_const = cur_const - mdl_prev_const;
            d_core  = cur_core - mdl_prev_core;
            if (mdl_stale && d_const >= {32'd0, mdl_min}) drop_window();
            mdl_acc_const = mdl_acc_const + d_const;
            mdl_acc_core  = mdl_acc_core + d_core;
        end
        if (act != ACT_EVAL) begin
            mdl_prev_const = cur_const;
            mdl_prev_core  = cur_core;
        end
        if (act == ACT_EVAL || act == ACT_ACC_EVAL) begin
            if (mdl_acc_const >= {32'd0, mdl_min}) begin
                prod = {64'd0, mdl_acc_const} * {98'd0, mdl_mult};
                if (mdl_div == '0) begin
                    ns = '1;
                end else begin
                    quot = prod / {96'd0, mdl_div};
                    ns = (quot[127:64] != '0) ? '1 : quot[63:0];
                end
                if (ns == '0) begin
                    khz_full = {32'd0, mdl_max};
                end else begin
                    prod = {64'd0, mdl_acc_core} * {96'd0, USEC_PER_SEC_K};
                    quot = prod / {64'd0, ns};
                    khz_full = (quot > {96'd0, mdl_max}) ? {32'd0, mdl_max} : quot[63:0];
                end
                scale_full = '0;
                if (mdl_max != '0)
                    scale_full = (khz_full * {53'd0, SCALE_ONE}) / {32'd0, mdl_max};
                beat.valid = 1'b1;
                beat.khz   = khz_full[KHZ_W-1:0];
                beat.scale = scale_full[SCALE_W-1:0];
                drop_window();
            end else if (mdl_acc_const != '0) begin
                mdl_stale = 1'b1;
            end
        end
        return beat;
    endfunction

    task automatic send_item(input t_action act, input logic [CNT_W-1:0] c,
                             input logic [CNT_W-1:0] k);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {k, c};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_scales.push_back(compute_freq_scale(act, c, k));
        items_sent++;
    endtask

    // Evaluate ignores the counters, so send random ones without moving the snapshot
    task automatic step(input t_action act, input logic [CNT_W-1:0] dc,
                        input logic [CNT_W-1:0] dk);
        if (act == ACT_EVAL) begin
            send_item(act, {$urandom, $urandom}, {$urandom, $urandom});
        end else begin
            gen_const = gen_const + dc;
            gen_core  = gen_core + dk;
            send_item(act, gen_const, gen_core);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_scales.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_SAMPLE_TICKS: mdl_min  = val;
            CFG_TICK_NS_MULT:     mdl_mult = val[MULT_W-1:0];
            CFG_TICK_NS_DIV:      mdl_div  = val;
            CFG_MAX_FREQ_KHZ:     mdl_max  = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] min_ticks, input logic [31:0] mult_word,
                              input logic [31:0] div, input logic [31:0] max_khz);
        wait_drained();
        write_reg(CFG_MIN_SAMPLE_TICKS, min_ticks);
        write_reg(CFG_TICK_NS_MULT, mult_word);
        write_reg(CFG_TICK_NS_DIV, div);
        write_reg(CFG_MAX_FREQ_KHZ, max_khz);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] draw_tick_delta();
        logic [CNT_W-1:0] base;
        base = (mdl_min == '0) ? 64'd64 : {32'd0, mdl_min};
        if ($urandom_range(0, 15) == 0) return '0;
        return (base * 64'($urandom_range(0, 1600))) / 64'd1024
               + 64'($urandom_range(0, 2));
    endfunction

    // Aim the core delta around the full-speed ratio so the cap is hit only sometimes
    function automatic logic [CNT_W-1:0] draw_core_delta(input logic [CNT_W-1:0] dc);
        logic [CNT_W-1:0] ratio;
        logic [CNT_W-1:0] wide_max;
        wide_max = {32'd0, mdl_max};
        ratio = 64'd1;
        if (mdl_div != '0)
            ratio = (wide_max * {34'd0, mdl_mult}) / ({32'd0, mdl_div} * 64'd1000000) + 64'd1;
        return (dc * ratio * 64'($urandom_range(0, 1300))) >> 10;
    endfunction

    task automatic send_window();
        int               n_acc;
        logic [CNT_W-1:0] dc;
        if ($urandom_range(0, 3) == 0) step(ACT_RESYNC, {$urandom, $urandom}, {$urandom, $urandom});
        n_acc = $urandom_range(1, 4);
        repeat (n_acc - 1) begin
            dc = draw_tick_delta();
            step(ACT_ACCUM, dc, draw_core_delta(dc));
        end
        dc = draw_tick_delta();
        if ($urandom_range(0, 1) == 0) begin
            step(ACT_ACC_EVAL, dc, draw_core_delta(dc));
        end else begin
            step(ACT_ACCUM, dc, draw_core_delta(dc));
            step(ACT_EVAL, '0, '0);
        end
    endtask

    task automatic send_noise();
        t_action          act;
        logic [CNT_W-1:0] dc;
        act = t_action'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) begin
            step(act, {$urandom, $urandom}, {$urandom, $urandom});
        end else begin
            dc = draw_tick_delta();
            step(act, dc, draw_core_delta(dc));
        end
    endtask

    task automatic run_windows(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n) begin
            no_idle = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 7) send_window();
            else send_noise();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_directed_defaults();
        step(ACT_ACCUM, '0, '0);
        step(ACT_EVAL, '0, '0);
        step(ACT_ACCUM, 64'd30, 64'd3000);
        step(ACT_EVAL, '0, '0);
        step(ACT_ACCUM, 64'd100, 64'd10000);
        step(ACT_ACC_EVAL, 64'd58, 64'd5800);
        gen_const = '1;
        gen_core  = '1;
        step(ACT_RESYNC, '0, '0);
        step(ACT_ACC_EVAL, 64'd100, 64'd10000);
        step(ACT_ACCUM, 64'd1000, 64'h8000_0000_0000_0000);
        step(ACT_EVAL, '0, '0);
        step(ACT_EVAL, '0, '0);
        step(ACT_ACC_EVAL, '1, 64'd5);
        step(ACT_ACC_EVAL, 64'd58, 64'd6000);
        step(ACT_ACCUM, 64'd57, 64'd6000);
        step(ACT_EVAL, '0, '0);
        step(ACT_ACCUM, 64'd57, 64'd6000);
        step(ACT_EVAL, '0, '0);
    endtask

    task automatic test_config_corners();
        set_config(32'd0, RST_TICK_NS_MULT, RST_TICK_NS_DIV, RST_MAX_FREQ_KHZ);
        step(ACT_EVAL, '0, '0);
        step(ACT_ACC_EVAL, '0, 64'd5);
        set_config(32'd1, RST_TICK_NS_MULT, 32'd0, RST_MAX_FREQ_KHZ);
        step(ACT_ACC_EVAL, 64'd10, 64'd1000);
        set_config(32'd1, RST_TICK_NS_MULT, RST_TICK_NS_DIV, 32'd0);
        step(ACT_ACC_EVAL, 64'd100, 64'd10000);
        set_config('1, '1, '1, '1);
        step(ACT_ACCUM, 64'h1_0000_0000, 64'd1);
        step(ACT_ACC_EVAL, 64'h1_0000_0000, 64'h8000_0000_0000_0000);
        set_config(32'd1, 32'd1000000000, 32'd1, RST_MAX_FREQ_KHZ);
        step(ACT_ACC_EVAL, 64'd3, 64'd2000);
    endtask

    task automatic test_random_windows(input logic [31:0] min_ticks,
                                       input logic [31:0] mult_word,
                                       input logic [31:0] div,
                                       input logic [31:0] max_khz, input int n);
        set_config(min_ticks, mult_word, div, max_khz);
        run_windows(n);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        hold_req = 900;
        no_idle  = 1'b1;
        while (hold_req != 0 || items_sent % 30 != 0) begin
            if (hold_req == 0 && $urandom_range(0, 9) == 0) break;
            send_window();
        end
        run_windows(20);
    endtask

    task automatic test_sender_pause();
        run_windows(20);
        wait_drained();
        run_windows(20);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_MIN_SAMPLE_TICKS;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_ACCUM;
        mdl_min  = RST_MIN_SAMPLE_TICKS;
        mdl_mult = RST_TICK_NS_MULT;
        mdl_div  = RST_TICK_NS_DIV;
        mdl_max  = RST_MAX_FREQ_KHZ;
        mdl_prev_const = '0;
        mdl_prev_core  = '0;
        drop_window();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_config_corners();
        test_random_windows(RST_MIN_SAMPLE_TICKS, RST_TICK_NS_MULT, RST_TICK_NS_DIV,
                            RST_MAX_FREQ_KHZ, 60);
        test_random_windows(32'd3000, RST_TICK_NS_MULT, RST_TICK_NS_DIV, 32'd2803200, 50);
        test_random_windows($urandom_range(1, 5000),
                            $urandom_range(1, 1000000000) | ($urandom_range(0, 3) << 30),
                            $urandom_range(1, 5000), 32'd3187200, 50);
        test_random_windows($urandom, $urandom, $urandom, $urandom, 40);
        test_random_windows(32'd1, 32'd1000000000, 32'd1000000, $urandom, 40);
        test_output_backpressure();
        test_random_windows(RST_MIN_SAMPLE_TICKS, RST_TICK_NS_MULT, RST_TICK_NS_DIV,
                            RST_MAX_FREQ_KHZ, 10);
        test_sender_pause();
        test_random_windows($urandom_range(1, 200), $urandom_range(1, 4000),
                            $urandom_range(1, 200), $urandom, 40);

        wait_drained();
        repeat (250) @(posedge i_clk);
        if (err_cnt == 0 && pending_scales.size() == 0) begin
            $display("[cycle_counter_freq_scale_estimator] OK");
        end else begin
            $display("[cycle_counter_freq_scale_estimator] ERROR");
        end
        $finish;
    end

    initial begin : result_monitor
        int          stall;
        t_scale_beat got;
        t_scale_beat want;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                stall = hold_req;
                hold_req = 0;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            got.valid = m_axis_tuser;
            got.scale = m_axis_tdata[SCALE_W-1:0];
            got.khz   = m_axis_tdata[SCALE_W +: KHZ_W];
            if (pending_scales.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected beat: valid=%0d scale=%0d khz=%0d",
                             got.valid, got.scale, got.khz);
            end else begin
                want = pending_scales.pop_front();
                if (got.valid !== want.valid || got.scale !== want.scale ||
                    got.khz !== want.khz) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: exp v=%0d scale=%0d khz=%0d, got v=%0d scale=%0d khz=%0d",
                                 want.valid, want.scale, want.khz,
                                 got.valid, got.scale, got.khz);
                end
            end
        end
    end

endmodule
